// File: src/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared types and constants of the escape framer with XOR check byte.
// ----------------------------------------------------------------------------
package ecb_pkg;

  // Frame bytes
  localparam logic [7:0] FLAG_BYTE = 8'hFF;
  localparam logic [7:0] ESC_BYTE  = 8'hFE;

  // Frame status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SRC_LONG  = 2'd1;
  localparam logic [1:0] STATUS_FRM_LONG  = 2'd2;

  // Configuration register indexes and reset values
  localparam logic        REG_MAX_SOURCE = 1'b0;
  localparam logic        REG_MAX_FRAME  = 1'b1;
  localparam logic [11:0] MAX_SOURCE_RST = 12'd1020;
  localparam logic [11:0] MAX_FRAME_RST  = 12'd1024;
  localparam int          LIMIT_WIDTH    = 12;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  // One classified source byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;  // start flags go out before this byte
    logic       esc;    // byte must be escaped
  } entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Emission steps of the back end
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG1,
    ST_FLAG2,
    ST_ESC,
    ST_DATA,
    ST_CHK_ESC,
    ST_CHK,
    ST_CLOSE
  } step_t;

endpackage

// File: src/ecb_front.sv
// ----------------------------------------------------------------------------
// ecb_front
// Accepts source bytes, marks the first byte of each message and the bytes
// that need an escape, and hands them to the queue.
// ----------------------------------------------------------------------------
module ecb_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  ecb_pkg::queue_status_t q_status,
  output logic                   push,
  output ecb_pkg::entry_t        push_entry
);

  logic inside_frame;
  logic inside_frame_next;

  // Take a transaction whenever the queue has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Classify the byte
  always_comb begin
    push_entry.data  = data_byte;
    push_entry.last  = last_byte;
    push_entry.first = !inside_frame;
    push_entry.esc   = (data_byte == ecb_pkg::FLAG_BYTE) ||
                       (data_byte == ecb_pkg::ESC_BYTE);
  end

  // Track message boundaries
  always_comb begin
    inside_frame_next = inside_frame;
    if (push) begin
      inside_frame_next = !last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
    end else begin
      inside_frame <= inside_frame_next;
    end
  end

endmodule

// File: src/ecb_queue.sv
// ----------------------------------------------------------------------------
// ecb_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module ecb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ecb_pkg::entry_t        push_entry,
  input  logic                   pop,
  output ecb_pkg::entry_t        head,
  output ecb_pkg::queue_status_t q_status
);

  localparam int PtrW = ecb_pkg::QPTR_WIDTH;
  localparam int CntW = ecb_pkg::QPTR_WIDTH + 1;

  ecb_pkg::entry_t slots [ecb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head           = slots[rd_ptr];
  assign q_status.full  = (count == CntW'(ecb_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: src/ecb_back.sv
// ----------------------------------------------------------------------------
// ecb_back
// Expands queued bytes into frame bytes, one per cycle unless stalled: start
// flags, escapes, data, check byte and closing flag with its status.
// ----------------------------------------------------------------------------
module ecb_back #(
  parameter int COUNTER_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ecb_pkg::entry_t        head,
  input  ecb_pkg::queue_status_t q_status,
  output logic                   pop,
  input  logic [11:0]            max_source_length,
  input  logic [11:0]            max_frame_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   run_end,
  output logic                   frame_end,
  output logic [1:0]             frame_status
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int CmpW = COUNTER_WIDTH + 2;
  localparam logic [CW-1:0] CountMax = '1;

  ecb_pkg::step_t state;
  ecb_pkg::step_t state_next;
  ecb_pkg::step_t cur_step;
  ecb_pkg::step_t step_after;

  logic [7:0]    check;
  logic [7:0]    check_next;
  logic [7:0]    chk_new;
  logic          chk_esc;
  logic          chk_new_esc;
  logic [CW-1:0] source_count;
  logic [CW-1:0] source_count_next;
  logic [CW-1:0] emitted_count;
  logic [CW-1:0] emitted_count_next;
  logic [CW-1:0] emitted_sat;
  logic [CW-1:0] source_sat;
  logic [CW-1:0] total;
  logic          fire;

  logic [7:0]    byte_next;
  logic          run_end_next;
  logic          frame_end_next;
  logic [1:0]    status_next;

  // Produce a byte when there is work and the output slot frees up
  assign fire = !q_status.empty && (!out_valid || out_ready);
  assign pop  = fire && (step_after == ecb_pkg::ST_IDLE);

  assign chk_new     = (head.first ? 8'h00 : check) ^ head.data;
  assign chk_new_esc = (chk_new == ecb_pkg::FLAG_BYTE) || (chk_new == ecb_pkg::ESC_BYTE);
  assign chk_esc     = (check == ecb_pkg::FLAG_BYTE) || (check == ecb_pkg::ESC_BYTE);

  assign emitted_sat = (emitted_count == CountMax) ? emitted_count : emitted_count + CW'(1);
  assign source_sat  = (source_count == CountMax) ? source_count : source_count + CW'(1);
  assign total       = emitted_sat;

  // Pick the step for the head entry and the step that follows it
  always_comb begin
    if (state == ecb_pkg::ST_IDLE) begin
      if (head.first) begin
        cur_step = ecb_pkg::ST_FLAG1;
      end else if (head.esc) begin
        cur_step = ecb_pkg::ST_ESC;
      end else begin
        cur_step = ecb_pkg::ST_DATA;
      end
    end else begin
      cur_step = state;
    end

    case (cur_step)
      ecb_pkg::ST_FLAG1:   step_after = ecb_pkg::ST_FLAG2;
      ecb_pkg::ST_FLAG2:   step_after = head.esc ? ecb_pkg::ST_ESC : ecb_pkg::ST_DATA;
      ecb_pkg::ST_ESC:     step_after = ecb_pkg::ST_DATA;
      ecb_pkg::ST_DATA: begin
        if (head.last) begin
          step_after = chk_new_esc ? ecb_pkg::ST_CHK_ESC : ecb_pkg::ST_CHK;
        end else begin
          step_after = ecb_pkg::ST_IDLE;
        end
      end
      ecb_pkg::ST_CHK_ESC: step_after = ecb_pkg::ST_CHK;
      ecb_pkg::ST_CHK:     step_after = ecb_pkg::ST_CLOSE;
      ecb_pkg::ST_CLOSE:   step_after = ecb_pkg::ST_IDLE;
      default:             step_after = ecb_pkg::ST_IDLE;
    endcase

    state_next = fire ? step_after : state;
  end

  // Form the byte and flags of the current step
  always_comb begin
    byte_next      = ecb_pkg::FLAG_BYTE;
    run_end_next   = 1'b0;
    frame_end_next = 1'b0;
    status_next    = ecb_pkg::STATUS_OK;
    case (cur_step)
      ecb_pkg::ST_FLAG1:   byte_next = ecb_pkg::FLAG_BYTE;
      ecb_pkg::ST_FLAG2:   byte_next = ecb_pkg::FLAG_BYTE;
      ecb_pkg::ST_ESC:     byte_next = ecb_pkg::ESC_BYTE;
      ecb_pkg::ST_DATA: begin
        byte_next    = head.esc ? (head.data ^ ecb_pkg::ESC_BYTE) : head.data;
        run_end_next = !head.last;
      end
      ecb_pkg::ST_CHK_ESC: byte_next = ecb_pkg::ESC_BYTE;
      ecb_pkg::ST_CHK:     byte_next = chk_esc ? (check ^ ecb_pkg::ESC_BYTE) : check;
      ecb_pkg::ST_CLOSE: begin
        byte_next      = ecb_pkg::FLAG_BYTE;
        run_end_next   = 1'b1;
        frame_end_next = 1'b1;
        // source length is tested before frame length
        if (CmpW'(source_count) > CmpW'(max_source_length)) begin
          status_next = ecb_pkg::STATUS_SRC_LONG;
        end else if (CmpW'(total) > CmpW'(max_frame_length)) begin
          status_next = ecb_pkg::STATUS_FRM_LONG;
        end else begin
          status_next = ecb_pkg::STATUS_OK;
        end
      end
      default: byte_next = ecb_pkg::FLAG_BYTE;
    endcase
  end

  // Update check byte and saturating counters
  always_comb begin
    check_next         = check;
    source_count_next  = source_count;
    emitted_count_next = emitted_count;
    if (fire) begin
      emitted_count_next = (cur_step == ecb_pkg::ST_FLAG1) ? CW'(1) : emitted_sat;
      if (cur_step == ecb_pkg::ST_DATA) begin
        check_next        = chk_new;
        source_count_next = head.first ? CW'(1) : source_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ecb_pkg::ST_IDLE;
      check         <= 8'h00;
      source_count  <= '0;
      emitted_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      check         <= check_next;
      source_count  <= source_count_next;
      emitted_count <= emitted_count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte     <= byte_next;
      run_end      <= run_end_next;
      frame_end    <= frame_end_next;
      frame_status <= status_next;
    end
  end

endmodule

// File: src/escape_framer_xor_bcc.sv
// ----------------------------------------------------------------------------
// escape_framer_xor_bcc
// Byte-stuffing framer with start flags, escapes, XOR check byte and a
// closing flag that carries the frame status.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   input     in_valid / in_ready     data_byte, last_byte
//   output    out_valid / out_ready   out_byte, run_end, frame_end, frame_status
//   config    cfg_wr_en               cfg_index, cfg_data
//
// The back end emits one frame byte per cycle while the output is not stalled;
// a source byte causes 1 to 7 frame bytes, typically 1 or 2.
// A four-entry queue lets the input keep accepting while the output stalls.
// Synchronous reset clears the queue, the step sequencer and the counters and
// loads the limit registers with 1020 and 1024.
// ----------------------------------------------------------------------------
module escape_framer_xor_bcc #(
  parameter int COUNTER_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_end,
  output logic        frame_end,
  output logic [1:0]  frame_status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic [ecb_pkg::LIMIT_WIDTH-1:0] max_source_length;
  logic [ecb_pkg::LIMIT_WIDTH-1:0] max_frame_length;
  ecb_pkg::queue_status_t          q_status;
  ecb_pkg::entry_t                 push_entry;
  ecb_pkg::entry_t                 head;
  logic                            push;
  logic                            pop;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_source_length <= ecb_pkg::MAX_SOURCE_RST;
      max_frame_length  <= ecb_pkg::MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ecb_pkg::REG_MAX_SOURCE: max_source_length <= cfg_data;
        ecb_pkg::REG_MAX_FRAME:  max_frame_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  ecb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  ecb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  ecb_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .q_status          (q_status),
    .pop               (pop),
    .max_source_length (max_source_length),
    .max_frame_length  (max_frame_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .run_end           (run_end),
    .frame_end         (frame_end),
    .frame_status      (frame_status)
  );

endmodule
